// File: rtl/sss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sss_pkg;

    localparam int MAX_ENTRIES = 4096;
    localparam int VEC_LEN     = 1024;

    typedef enum logic [1:0] {
        FUNC_WRITE_ENTRY = 2'd0,
        FUNC_WRITE_VEC   = 2'd1,
        FUNC_RUN         = 2'd2,
        FUNC_READ        = 2'd3
    } func_t;

    localparam logic [0:0] REG_STEP_COEF   = 1'b0;
    localparam logic [0:0] REG_ENTRY_COUNT = 1'b1;

    typedef struct packed {
        logic [1:0]         func;
        logic [11:0]        slot;
        logic [9:0]         row;
        logic [9:0]         col;
        logic signed [31:0] coef;
        logic [9:0]         vec_index;
        logic signed [31:0] real_in;
        logic signed [31:0] imag_in;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] real_out;
        logic signed [31:0] imag_out;
        logic               done_res;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_ENTRY,
        ST_RD_OPER,
        ST_MUL1,
        ST_MUL2,
        ST_SUM,
        ST_WRITE,
        ST_READ,
        ST_RESP
    } back_state_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -66'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/sss_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module sss_queue
    import sss_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push_valid,
    output logic          push_ready,
    input  wire in_item_t push_item,
    output logic          pop_valid,
    input  wire logic     pop_ready,
    output in_item_t      pop_item
);

    in_item_t   slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push_fire;
    logic       pop_fire;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push_fire ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop_fire ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push_fire} - {1'b0, pop_fire};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule
`default_nettype wire

// File: rtl/sss_back.sv
`timescale 1ns / 1ps
`default_nettype none
module sss_back
    import sss_pkg::*;
#(
    parameter int FRAC_BITS   = 24
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire in_item_t           item,
    input  wire logic signed [31:0] step_coef,
    input  wire logic [12:0]        entry_count,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output out_item_t               res
);

    localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int VW = $clog2(VEC_LEN);
    localparam int NW = EW + 1;

    logic [9:0]         erow_mem  [MAX_ENTRIES];
    logic [9:0]         ecol_mem  [MAX_ENTRIES];
    logic signed [31:0] ecoef_mem [MAX_ENTRIES];
    logic signed [31:0] re_mem    [VEC_LEN];
    logic signed [31:0] im_mem    [VEC_LEN];

    back_state_t        state_reg;
    back_state_t        state_next;
    logic [NW-1:0]      idx_reg;
    logic [NW-1:0]      idx_next;
    logic [NW-1:0]      limit_reg;
    logic               pass_reg;
    logic               pass_next;
    logic [9:0]         erow_q_reg;
    logic [9:0]         ecol_q_reg;
    logic signed [31:0] ecoef_q_reg;
    logic signed [31:0] p1_reg;
    logic signed [63:0] p2_reg;
    logic signed [31:0] sum_reg;
    logic signed [31:0] rd_re_reg;
    logic signed [31:0] rd_im_reg;
    out_item_t          res_reg;
    logic               res_valid_reg;
    logic               load;
    logic               finish;
    logic               rd_load;
    logic               re_we;
    logic               im_we;
    logic [VW-1:0]      r_addr;
    logic [VW-1:0]      c_addr;
    logic [VW-1:0]      vi_addr;
    logic [VW-1:0]      re_raddr;
    logic [VW-1:0]      im_raddr;
    logic [VW-1:0]      re_waddr;
    logic [VW-1:0]      im_waddr;
    logic signed [31:0] re_wdata;
    logic signed [31:0] im_wdata;
    logic signed [31:0] oper_val;
    logic signed [31:0] acc_val;
    logic signed [63:0] prod1;
    logic signed [63:0] sh1;
    logic signed [63:0] sh2;
    logic signed [65:0] wide_sum;
    logic [NW-1:0]      lim_calc;

    assign r_addr   = erow_q_reg[VW-1:0];
    assign c_addr   = ecol_q_reg[VW-1:0];
    assign vi_addr  = item.vec_index[VW-1:0];
    assign oper_val = pass_reg ? rd_re_reg : rd_im_reg;
    assign acc_val  = pass_reg ? rd_im_reg : rd_re_reg;
    assign prod1    = ecoef_q_reg * oper_val;
    assign sh1      = prod1 >>> FRAC_BITS;
    assign sh2      = p2_reg >>> FRAC_BITS;
    assign wide_sum = pass_reg ? (66'(acc_val) - 66'(sh2)) : (66'(acc_val) + 66'(sh2));
    assign lim_calc = (entry_count > 13'(MAX_ENTRIES)) ? NW'(MAX_ENTRIES) : NW'(entry_count);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        pass_next  = pass_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid && !res_valid_reg)
                begin
                    unique case (func_t'(item.func))
                        FUNC_RUN:
                        begin
                            idx_next  = '0;
                            pass_next = 1'b0;
                            state_next = (lim_calc == '0) ? ST_RESP : ST_RD_ENTRY;
                        end
                        FUNC_READ:  state_next = ST_READ;
                        default:    state_next = ST_RESP;
                    endcase
                end
            end
            ST_RD_ENTRY: state_next = ST_RD_OPER;
            ST_RD_OPER:  state_next = ST_MUL1;
            ST_MUL1:     state_next = ST_MUL2;
            ST_MUL2:     state_next = ST_SUM;
            ST_SUM:      state_next = ST_WRITE;
            ST_WRITE:
            begin
                if (idx_reg + 1'b1 == limit_reg)
                begin
                    idx_next = '0;
                    if (pass_reg)
                        state_next = ST_RESP;
                    else
                    begin
                        pass_next  = 1'b1;
                        state_next = ST_RD_ENTRY;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_RD_ENTRY;
                end
            end
            ST_READ:     state_next = ST_RESP;
            ST_RESP:     state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        load       = (state_reg == ST_IDLE) && item_valid && !res_valid_reg;
        finish     = (state_reg == ST_RESP);
        item_ready = load;
    end

    always_comb
    begin
        rd_load  = load || (state_reg == ST_RD_OPER);
        re_raddr = (state_reg == ST_RD_OPER) ? (pass_reg ? c_addr : r_addr) : vi_addr;
        im_raddr = (state_reg == ST_RD_OPER) ? (pass_reg ? r_addr : c_addr) : vi_addr;
        re_we    = (load && (func_t'(item.func) == FUNC_WRITE_VEC))
                   || ((state_reg == ST_WRITE) && !pass_reg);
        im_we    = (load && (func_t'(item.func) == FUNC_WRITE_VEC))
                   || ((state_reg == ST_WRITE) && pass_reg);
        re_waddr = (state_reg == ST_WRITE) ? r_addr : vi_addr;
        im_waddr = (state_reg == ST_WRITE) ? r_addr : vi_addr;
        re_wdata = (state_reg == ST_WRITE) ? sum_reg : item.real_in;
        im_wdata = (state_reg == ST_WRITE) ? sum_reg : item.imag_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            idx_reg       <= '0;
            pass_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pass_reg  <= pass_next;
            if (finish)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            limit_reg <= lim_calc;
            res_reg   <= '{real_out: '0, imag_out: '0, done_res: 1'b1};
            if (func_t'(item.func) == FUNC_WRITE_ENTRY)
            begin
                erow_mem[item.slot[EW-1:0]]  <= item.row;
                ecol_mem[item.slot[EW-1:0]]  <= item.col;
                ecoef_mem[item.slot[EW-1:0]] <= item.coef;
            end
        end
        if (re_we)
            re_mem[re_waddr] <= re_wdata;
        if (im_we)
            im_mem[im_waddr] <= im_wdata;
        if (rd_load)
        begin
            rd_re_reg <= re_mem[re_raddr];
            rd_im_reg <= im_mem[im_raddr];
        end
        if (state_reg == ST_READ)
            res_reg <= '{real_out: rd_re_reg, imag_out: rd_im_reg, done_res: 1'b1};
        if (state_reg == ST_RD_ENTRY)
        begin
            erow_q_reg  <= erow_mem[idx_reg[EW-1:0]];
            ecol_q_reg  <= ecol_mem[idx_reg[EW-1:0]];
            ecoef_q_reg <= ecoef_mem[idx_reg[EW-1:0]];
        end
        if (state_reg == ST_MUL1)
            p1_reg <= sat32(66'(sh1));
        if (state_reg == ST_MUL2)
            p2_reg <= p1_reg * step_coef;
        if (state_reg == ST_SUM)
            sum_reg <= sat32(wide_sum);
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
`default_nettype wire

// File: rtl/sparse_symplectic_step_core.sv
// Sparse split-step engine. Entry writes, element writes and element reads each pass through
// the front queue and the back sequencer. A run item makes two passes over entry_count
// entries, with entry_count capped at the table size: each entry of each pass goes through
// entry fetch, operand fetch, two registered multiplies, a saturating sum and a write-back
// in turn, since an entry may depend on the update made by the one before it.
// Stores come up undefined and must be written before they are read.
`timescale 1ns / 1ps
`default_nettype none
module sparse_symplectic_step_core
    import sss_pkg::*;
#(
    parameter int FRAC_BITS   = 24
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_item_t    in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output out_item_t        out_data,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    logic signed [31:0] step_coef_reg;
    logic [12:0]        entry_count_reg;
    logic               q_valid;
    logic               q_ready;
    in_item_t           q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_coef_reg   <= '0;
            entry_count_reg <= '0;
        end
        else if (cfg_we && !cfg_index[1])
        begin
            if (cfg_index[0] == REG_STEP_COEF)
                step_coef_reg <= cfg_data;
            else if (cfg_index[0] == REG_ENTRY_COUNT)
                entry_count_reg <= cfg_data[12:0];
        end
    end

    sss_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_item  (in_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    sss_back #(
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (q_valid),
        .item_ready  (q_ready),
        .item        (q_item),
        .step_coef   (step_coef_reg),
        .entry_count (entry_count_reg),
        .res_valid   (out_valid),
        .res_ready   (out_ready),
        .res         (out_data)
    );

endmodule
`default_nettype wire
